### rtl/arpc_pkg.sv
`default_nettype none
// -----------------------------------------------------------------------------
// arpc_pkg: shared types and constants of the ARP responder
// Command, status and opcode codes, cache geometry and the request/result
// structs passed between the top level and the cache engine.
// -----------------------------------------------------------------------------
package arpc_pkg;

	localparam int CACHE_DEPTH = 16;
	localparam int IDX_W       = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;

	localparam int IP_W  = 32;
	localparam int MAC_W = 48;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 48;
	localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_IP  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_MAC = 1'd1;

	localparam logic [1:0] CMD_RX     = 2'd0;
	localparam logic [1:0] CMD_LOOKUP = 2'd1;
	localparam logic [1:0] CMD_BUILD  = 2'd2;

	localparam logic [2:0] STAT_OK         = 3'd0;
	localparam logic [2:0] STAT_BAD_HW     = 3'd1;
	localparam logic [2:0] STAT_BAD_PROTO  = 3'd2;
	localparam logic [2:0] STAT_NOT_US     = 3'd3;
	localparam logic [2:0] STAT_REPLY_ABS  = 3'd4;
	localparam logic [2:0] STAT_BAD_OPCODE = 3'd5;

	localparam logic [15:0] HW_ETHERNET = 16'h0001;
	localparam logic [15:0] PROTO_IPV4  = 16'h0800;
	localparam logic [15:0] OP_REQUEST  = 16'd1;
	localparam logic [15:0] OP_REPLY    = 16'd2;

	localparam logic [1:0] FRAME_OP_REQUEST = 2'd1;
	localparam logic [1:0] FRAME_OP_REPLY   = 2'd2;

	localparam logic [MAC_W-1:0] MAC_BCAST = {(MAC_W/8){8'hff}};

	typedef struct packed {
		logic             learn;
		logic [IP_W-1:0]  ip;
		logic [MAC_W-1:0] mac;
	} cache_req_t;

	typedef struct packed {
		logic             hit;
		logic             full;
		logic [MAC_W-1:0] mac;
	} cache_res_t;

	typedef struct packed {
		logic             send_frame;
		logic [2:0]       status;
		logic [MAC_W-1:0] frame_dest_mac;
		logic [1:0]       out_opcode;
		logic [MAC_W-1:0] out_sender_mac;
		logic [IP_W-1:0]  out_sender_ip;
		logic [MAC_W-1:0] out_target_mac;
		logic [IP_W-1:0]  out_target_ip;
		logic             hit;
		logic [MAC_W-1:0] hit_mac;
		logic             table_full;
	} result_t;

endpackage
`default_nettype wire

### rtl/arpc_ram.sv
`default_nettype none
// -----------------------------------------------------------------------------
// arpc_ram: generic single-clock RAM
// One write port, one read port, read data registered.
// -----------------------------------------------------------------------------
module arpc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule
`default_nettype wire

### rtl/arpc_cache.sv
`default_nettype none
// -----------------------------------------------------------------------------
// arpc_cache: ARP address cache engine
// Scans every entry of the IP/MAC RAM once per request, tracks the first
// matching and the first free entry, then writes back on a learn request.
// -----------------------------------------------------------------------------
module arpc_cache import arpc_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire cache_req_t req,
	output logic            done,
	output cache_res_t      res
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_DEPTH - 1);

	logic [1:0]             state_q;
	cache_req_t             key_q;
	logic [IDX_W-1:0]       rd_addr_q;
	logic                   issue_q;
	logic                   cmp_s1;
	logic [IDX_W-1:0]       idx_s1;
	logic [CACHE_DEPTH-1:0] valid_q;
	logic                   found_q;
	logic [IDX_W-1:0]       found_idx_q;
	logic [MAC_W-1:0]       found_mac_q;
	logic                   free_q;
	logic [IDX_W-1:0]       free_idx_q;
	cache_res_t             res_q;
	logic                   done_q;

	logic                   wr_en;
	logic [IDX_W-1:0]       wr_addr;
	logic [IP_W+MAC_W-1:0]  rd_data;
	logic [IP_W-1:0]        rd_ip;
	logic [MAC_W-1:0]       rd_mac;
	logic                   match;
	logic                   empty;

	arpc_ram #(
		.WIDTH(IP_W + MAC_W),
		.DEPTH(CACHE_DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data({key_q.ip, key_q.mac}),
		.rd_addr(rd_addr_q),
		.rd_data(rd_data)
	);

	assign rd_ip  = rd_data[IP_W+MAC_W-1:MAC_W];
	assign rd_mac = rd_data[MAC_W-1:0];
	assign match  = cmp_s1 && valid_q[idx_s1] && (rd_ip == key_q.ip);
	assign empty  = cmp_s1 && !valid_q[idx_s1];

	// refresh a matching entry, otherwise fill the lowest free one
	assign wr_en   = (state_q == ST_DONE) && key_q.learn && (found_q || free_q);
	assign wr_addr = found_q ? found_idx_q : free_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			issue_q <= 1'b0;
			cmp_s1  <= 1'b0;
			valid_q <= '0;
			found_q <= 1'b0;
			free_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			cmp_s1 <= issue_q;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_SCAN;
						issue_q <= 1'b1;
						found_q <= 1'b0;
						free_q  <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (issue_q && rd_addr_q == LAST_IDX) begin
						issue_q <= 1'b0;
					end
					if (match && !found_q) begin
						found_q <= 1'b1;
					end
					if (empty && !free_q) begin
						free_q <= 1'b1;
					end
					if (cmp_s1 && idx_s1 == LAST_IDX) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (key_q.learn && !found_q && free_q) begin
						valid_q[free_idx_q] <= 1'b1;
					end
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= rd_addr_q;
		if (state_q == ST_IDLE && start) begin
			key_q     <= req;
			rd_addr_q <= '0;
		end else if (issue_q && rd_addr_q != LAST_IDX) begin
			rd_addr_q <= rd_addr_q + IDX_W'(1);
		end
		if (match && !found_q) begin
			found_idx_q <= idx_s1;
			found_mac_q <= rd_mac;
		end
		if (empty && !free_q) begin
			free_idx_q <= idx_s1;
		end
		if (state_q == ST_DONE) begin
			res_q.hit  <= found_q;
			res_q.full <= key_q.learn && !found_q && !free_q;
			res_q.mac  <= found_q ? found_mac_q : '0;
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule
`default_nettype wire

### rtl/arp_responder_with_cache.sv
`default_nettype none
// -----------------------------------------------------------------------------
// arp_responder_with_cache: ARP responder for one IPv4-over-Ethernet interface
// Takes one command per request and returns exactly one result per request.
// -----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries a command with its fields:
//   a parsed received ARP packet, a cache lookup or a request build.
//   Output channel (out_valid/out_stall) carries the result: an outgoing
//   frame, a status code, a lookup hit and a table-full flag.
//   local_ip and local_mac are set through cfg_write/cfg_index/cfg_data
//   while the block is idle.
//   A packet that passes the type checks and a lookup walk all 16 cache
//   entries through one RAM read port, one entry per cycle, then the packet
//   learns its sender; the result is registered once the scan is done.
//   Other commands skip the cache and go straight to the output register.
//   One request is in flight at a time; in_stall stays high from accept
//   until the result is loaded into the output register.
//   The output register holds its result while out_stall is high; the
//   block takes the next request meanwhile but will not overwrite it.
//   Reset clears the cache valid bits and both config registers.
// -----------------------------------------------------------------------------
module arp_responder_with_cache import arpc_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_write,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [1:0]            command,
	input  wire logic [15:0]           hw_type,
	input  wire logic [15:0]           proto_type,
	input  wire logic [15:0]           arp_opcode,
	input  wire logic [MAC_W-1:0]      sender_mac,
	input  wire logic [IP_W-1:0]       sender_ip,
	input  wire logic [IP_W-1:0]       target_ip,
	input  wire logic [IP_W-1:0]       query_ip,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic                       send_frame,
	output logic [2:0]                 status,
	output logic [MAC_W-1:0]           frame_dest_mac,
	output logic [1:0]                 out_opcode,
	output logic [MAC_W-1:0]           out_sender_mac,
	output logic [IP_W-1:0]            out_sender_ip,
	output logic [MAC_W-1:0]           out_target_mac,
	output logic [IP_W-1:0]            out_target_ip,
	output logic                       hit,
	output logic [MAC_W-1:0]           hit_mac,
	output logic                       table_full
);

	localparam logic [1:0] T_IDLE  = 2'd0;
	localparam logic [1:0] T_WAIT  = 2'd1;
	localparam logic [1:0] T_READY = 2'd2;

	logic [1:0]       state_q;
	logic [IP_W-1:0]  local_ip_q;
	logic [MAC_W-1:0] local_mac_q;
	logic             out_valid_q;
	result_t          out_q;

	logic [1:0]       cmd_q;
	logic             type_ok_q;
	logic [2:0]       type_stat_q;
	logic [15:0]      opcode_q;
	logic [MAC_W-1:0] sender_mac_q;
	logic [IP_W-1:0]  sender_ip_q;
	logic [IP_W-1:0]  target_ip_q;

	logic             accept;
	logic             type_ok;
	logic             cache_start;
	cache_req_t       cache_req;
	logic             cache_done;
	cache_res_t       cache_res;
	logic             load;
	result_t          result;

	assign accept  = in_valid && !in_stall;
	assign type_ok = (hw_type == HW_ETHERNET) && (proto_type == PROTO_IPV4);

	assign cache_start   = accept && (((command == CMD_RX) && type_ok) ||
	                                  (command == CMD_LOOKUP));
	assign cache_req.learn = (command == CMD_RX);
	assign cache_req.ip    = (command == CMD_RX) ? sender_ip : query_ip;
	assign cache_req.mac   = sender_mac;

	arpc_cache u_cache (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cache_start),
		.req   (cache_req),
		.done  (cache_done),
		.res   (cache_res)
	);

	assign load     = (state_q == T_READY) && (!out_valid_q || !out_stall);
	assign in_stall = (state_q != T_IDLE);

	always_comb begin
		result = '0;
		case (cmd_q)
			CMD_RX: begin
				if (!type_ok_q) begin
					result.status = type_stat_q;
				end else begin
					result.table_full = cache_res.full;
					if (opcode_q == OP_REQUEST) begin
						if (target_ip_q == local_ip_q) begin
							result.send_frame     = 1'b1;
							result.status         = STAT_OK;
							result.frame_dest_mac = sender_mac_q;
							result.out_opcode     = FRAME_OP_REPLY;
							result.out_sender_mac = local_mac_q;
							result.out_sender_ip  = local_ip_q;
							result.out_target_mac = sender_mac_q;
							result.out_target_ip  = sender_ip_q;
						end else begin
							result.status = STAT_NOT_US;
						end
					end else if (opcode_q == OP_REPLY) begin
						result.status = STAT_REPLY_ABS;
					end else begin
						result.status = STAT_BAD_OPCODE;
					end
				end
			end
			CMD_LOOKUP: begin
				result.hit     = cache_res.hit;
				result.hit_mac = cache_res.mac;
			end
			CMD_BUILD: begin
				result.send_frame     = 1'b1;
				result.frame_dest_mac = MAC_BCAST;
				result.out_opcode     = FRAME_OP_REQUEST;
				result.out_sender_mac = local_mac_q;
				result.out_sender_ip  = sender_ip_q;
				result.out_target_mac = MAC_BCAST;
				result.out_target_ip  = target_ip_q;
			end
			default: begin
				result = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_IDLE;
			out_valid_q <= 1'b0;
			local_ip_q  <= '0;
			local_mac_q <= '0;
		end else begin
			if (cfg_write) begin
				unique case (cfg_index)
					CFG_LOCAL_IP:  local_ip_q  <= cfg_data[IP_W-1:0];
					CFG_LOCAL_MAC: local_mac_q <= cfg_data[MAC_W-1:0];
					default: begin
					end
				endcase
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				T_IDLE: begin
					if (accept) begin
						state_q <= cache_start ? T_WAIT : T_READY;
					end
				end
				T_WAIT: begin
					if (cache_done) begin
						state_q <= T_READY;
					end
				end
				T_READY: begin
					if (load) begin
						state_q <= T_IDLE;
					end
				end
				default: begin
					state_q <= T_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q        <= command;
			type_ok_q    <= type_ok;
			type_stat_q  <= (hw_type != HW_ETHERNET) ? STAT_BAD_HW : STAT_BAD_PROTO;
			opcode_q     <= arp_opcode;
			sender_mac_q <= sender_mac;
			sender_ip_q  <= sender_ip;
			target_ip_q  <= target_ip;
		end
		if (load) begin
			out_q <= result;
		end
	end

	assign out_valid      = out_valid_q;
	assign send_frame     = out_q.send_frame;
	assign status         = out_q.status;
	assign frame_dest_mac = out_q.frame_dest_mac;
	assign out_opcode     = out_q.out_opcode;
	assign out_sender_mac = out_q.out_sender_mac;
	assign out_sender_ip  = out_q.out_sender_ip;
	assign out_target_mac = out_q.out_target_mac;
	assign out_target_ip  = out_q.out_target_ip;
	assign hit            = out_q.hit;
	assign hit_mac        = out_q.hit_mac;
	assign table_full     = out_q.table_full;

endmodule
`default_nettype wire

### rtl/arpc_chk.sv
`default_nettype none
// -----------------------------------------------------------------------------
// arpc_chk: port-level checker for the ARP responder
// Watches the top-level ports and flags handshake and result-field slips.
// -----------------------------------------------------------------------------
module arpc_chk import arpc_pkg::*; (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             in_valid,
	input wire logic             in_stall,
	input wire logic             out_valid,
	input wire logic             out_stall,
	input wire logic             send_frame,
	input wire logic [2:0]       status,
	input wire logic [MAC_W-1:0] frame_dest_mac,
	input wire logic [1:0]       out_opcode,
	input wire logic             hit,
	input wire logic [MAC_W-1:0] hit_mac
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(hit_mac)
			&& $stable(frame_dest_mac))
		else $error("stalled result changed");

	// one request in flight: stall right after an accept
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request accepted while busy");

	a_frame_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && send_frame |-> status == STAT_OK
			&& (out_opcode == FRAME_OP_REQUEST || out_opcode == FRAME_OP_REPLY))
		else $error("frame sent with bad status or opcode");

	a_no_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !send_frame |-> frame_dest_mac == '0 && out_opcode == '0)
		else $error("frame fields set without a frame");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> hit_mac == '0)
		else $error("hit_mac set on a miss");

endmodule

bind arp_responder_with_cache arpc_chk u_arpc_chk (.*);
`default_nettype wire

### bench/arp_checker.sv
`default_nettype none
// -----------------------------------------------------------------------------
// arp_checker: response predictor and scoreboard for the ARP responder
// Watches the config port and both request/result channels, keeps its own
// copy of the address cache and the local addresses, predicts the result of
// every accepted request and compares each delivered result field by field.
// -----------------------------------------------------------------------------
module arp_checker import arpc_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_write,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	input  wire logic                  in_stall,
	input  wire logic [1:0]            command,
	input  wire logic [15:0]           hw_type,
	input  wire logic [15:0]           proto_type,
	input  wire logic [15:0]           arp_opcode,
	input  wire logic [MAC_W-1:0]      sender_mac,
	input  wire logic [IP_W-1:0]       sender_ip,
	input  wire logic [IP_W-1:0]       target_ip,
	input  wire logic [IP_W-1:0]       query_ip,
	input  wire logic                  out_valid,
	input  wire logic                  out_stall,
	input  wire logic                  send_frame,
	input  wire logic [2:0]            status,
	input  wire logic [MAC_W-1:0]      frame_dest_mac,
	input  wire logic [1:0]            out_opcode,
	input  wire logic [MAC_W-1:0]      out_sender_mac,
	input  wire logic [IP_W-1:0]       out_sender_ip,
	input  wire logic [MAC_W-1:0]      out_target_mac,
	input  wire logic [IP_W-1:0]       out_target_ip,
	input  wire logic                  hit,
	input  wire logic [MAC_W-1:0]      hit_mac,
	input  wire logic                  table_full,
	output int                         mismatches,
	output int                         responses_due
);

	logic             cache_used [CACHE_DEPTH];
	logic [IP_W-1:0]  cache_ip   [CACHE_DEPTH];
	logic [MAC_W-1:0] cache_mac  [CACHE_DEPTH];
	logic [IP_W-1:0]  my_ip;
	logic [MAC_W-1:0] my_mac;

	result_t pending_responses[$];

	// Refresh the entry holding ip, else take the lowest free one.
	function automatic logic learn_sender(input logic [IP_W-1:0] ip,
			input logic [MAC_W-1:0] mac);
		for (int i = 0; i < CACHE_DEPTH; i++) begin
			if (cache_used[i] && cache_ip[i] == ip) begin
				cache_mac[i] = mac;
				return 1'b1;
			end
		end
		for (int i = 0; i < CACHE_DEPTH; i++) begin
			if (!cache_used[i]) begin
				cache_used[i] = 1'b1;
				cache_ip[i]   = ip;
				cache_mac[i]  = mac;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic result_t arp_response(input logic [1:0] cmd,
			input logic [15:0] hw, input logic [15:0] proto, input logic [15:0] op,
			input logic [MAC_W-1:0] smac, input logic [IP_W-1:0] sip,
			input logic [IP_W-1:0] tip, input logic [IP_W-1:0] qip);
		result_t r;
		r = '0;
		case (cmd)
			CMD_RX: begin
				if (hw != HW_ETHERNET) begin
					r.status = STAT_BAD_HW;
				end else if (proto != PROTO_IPV4) begin
					r.status = STAT_BAD_PROTO;
				end else begin
					r.table_full = !learn_sender(sip, smac);
					if (op == OP_REQUEST) begin
						if (tip == my_ip) begin
							r.send_frame     = 1'b1;
							r.status         = STAT_OK;
							r.frame_dest_mac = smac;
							r.out_opcode     = FRAME_OP_REPLY;
							r.out_sender_mac = my_mac;
							r.out_sender_ip  = my_ip;
							r.out_target_mac = smac;
							r.out_target_ip  = sip;
						end else begin
							r.status = STAT_NOT_US;
						end
					end else if (op == OP_REPLY) begin
						r.status = STAT_REPLY_ABS;
					end else begin
						r.status = STAT_BAD_OPCODE;
					end
				end
			end
			CMD_LOOKUP: begin
				for (int i = 0; i < CACHE_DEPTH; i++) begin
					if (!r.hit && cache_used[i] && cache_ip[i] == qip) begin
						r.hit     = 1'b1;
						r.hit_mac = cache_mac[i];
					end
				end
			end
			CMD_BUILD: begin
				r.send_frame     = 1'b1;
				r.frame_dest_mac = MAC_BCAST;
				r.out_opcode     = FRAME_OP_REQUEST;
				r.out_sender_mac = my_mac;
				r.out_sender_ip  = sip;
				r.out_target_mac = MAC_BCAST;
				r.out_target_ip  = tip;
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			for (int i = 0; i < CACHE_DEPTH; i++)
				cache_used[i] = 1'b0;
			my_ip  = '0;
			my_mac = '0;
			pending_responses.delete();
			mismatches    = 0;
			responses_due = 0;
		end else begin
			// Retire the delivered result first: it belongs to an older request.
			if (out_valid && !out_stall) begin
				if (pending_responses.size() == 0) begin
					$display("%0t: result with no request outstanding, status %h",
						$time, status);
					mismatches++;
				end else begin
					want = pending_responses.pop_front();
					check_field("send_frame", 64'(want.send_frame), 64'(send_frame));
					check_field("status", 64'(want.status), 64'(status));
					check_field("frame_dest_mac", 64'(want.frame_dest_mac),
						64'(frame_dest_mac));
					check_field("out_opcode", 64'(want.out_opcode), 64'(out_opcode));
					check_field("out_sender_mac", 64'(want.out_sender_mac),
						64'(out_sender_mac));
					check_field("out_sender_ip", 64'(want.out_sender_ip),
						64'(out_sender_ip));
					check_field("out_target_mac", 64'(want.out_target_mac),
						64'(out_target_mac));
					check_field("out_target_ip", 64'(want.out_target_ip),
						64'(out_target_ip));
					check_field("hit", 64'(want.hit), 64'(hit));
					check_field("hit_mac", 64'(want.hit_mac), 64'(hit_mac));
					check_field("table_full", 64'(want.table_full), 64'(table_full));
				end
			end
			if (cfg_write) begin
				case (cfg_index)
					CFG_LOCAL_IP:  my_ip  = cfg_data[IP_W-1:0];
					CFG_LOCAL_MAC: my_mac = cfg_data[MAC_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				pending_responses.push_back(arp_response(command, hw_type, proto_type,
					arp_opcode, sender_mac, sender_ip, target_ip, query_ip));
			responses_due = pending_responses.size();
		end
	end

endmodule
`default_nettype wire

### bench/tb.sv
`default_nettype none
// -----------------------------------------------------------------------------
// tb: top-level bench for the ARP responder with address cache
// Drives directed and random ARP commands through the request channel with
// bursty pacing, stalls the result channel on changing patterns, moves the
// local addresses between phases and leaves checking to arp_checker.
// -----------------------------------------------------------------------------
module tb;
	import arpc_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int POOL_SIZE      = 24;
	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PHASES         = 5;
	localparam int PHASE_ITEMS    = 200;

	typedef struct packed {
		logic [1:0]       cmd;
		logic [15:0]      hw;
		logic [15:0]      proto;
		logic [15:0]      op;
		logic [MAC_W-1:0] smac;
		logic [IP_W-1:0]  sip;
		logic [IP_W-1:0]  tip;
		logic [IP_W-1:0]  qip;
	} arp_req_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_write;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	logic [1:0]            command;
	logic [15:0]           hw_type;
	logic [15:0]           proto_type;
	logic [15:0]           arp_opcode;
	logic [MAC_W-1:0]      sender_mac;
	logic [IP_W-1:0]       sender_ip;
	logic [IP_W-1:0]       target_ip;
	logic [IP_W-1:0]       query_ip;
	logic                  out_valid;
	logic                  out_stall;
	logic                  send_frame;
	logic [2:0]            status;
	logic [MAC_W-1:0]      frame_dest_mac;
	logic [1:0]            out_opcode;
	logic [MAC_W-1:0]      out_sender_mac;
	logic [IP_W-1:0]       out_sender_ip;
	logic [MAC_W-1:0]      out_target_mac;
	logic [IP_W-1:0]       out_target_ip;
	logic                  hit;
	logic [MAC_W-1:0]      hit_mac;
	logic                  table_full;
	int                    mismatches;
	int                    responses_due;

	logic [IP_W-1:0] ip_pool [POOL_SIZE];
	logic [IP_W-1:0] local_ip_now;
	logic            hold_trigger;
	int              burst_left;

	arp_responder_with_cache dut (.*);
	arp_checker u_scoreboard (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [MAC_W-1:0] rand48();
		logic [63:0] v;
		v = {$urandom, $urandom};
		return v[MAC_W-1:0];
	endfunction

	function automatic arp_req_t mk(input logic [1:0] cmd, input logic [15:0] hw,
			input logic [15:0] proto, input logic [15:0] op, input logic [MAC_W-1:0] smac,
			input logic [IP_W-1:0] sip, input logic [IP_W-1:0] tip,
			input logic [IP_W-1:0] qip);
		arp_req_t r;
		r = {cmd, hw, proto, op, smac, sip, tip, qip};
		return r;
	endfunction

	// Mostly well-formed packets against a small address pool, so entries get
	// refreshed and looked up; the rest is malformed traffic and other commands.
	function automatic arp_req_t random_request();
		arp_req_t r;
		int pick;
		r = mk(2'($urandom_range(0, 2)), 16'($urandom), 16'($urandom), 16'($urandom),
			rand48(), $urandom, $urandom, $urandom);
		pick = $urandom_range(0, 99);
		if (pick < 50) begin
			r.cmd   = CMD_RX;
			r.hw    = HW_ETHERNET;
			r.proto = PROTO_IPV4;
			if ($urandom_range(0, 4) != 0)
				r.sip = ip_pool[$urandom_range(0, POOL_SIZE-1)];
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: begin
					r.op = OP_REQUEST;
					if ($urandom_range(0, 1) != 0)
						r.tip = local_ip_now;
				end
				5, 6, 7: r.op = OP_REPLY;
				default: ;
			endcase
		end else if (pick < 60) begin
			r.cmd = CMD_RX;
			if ($urandom_range(0, 1) != 0)
				r.hw = HW_ETHERNET;
		end else if (pick < 82) begin
			r.cmd = CMD_LOOKUP;
			if ($urandom_range(0, 3) != 0)
				r.qip = ip_pool[$urandom_range(0, POOL_SIZE-1)];
		end else if (pick < 96) begin
			r.cmd = CMD_BUILD;
		end else begin
			r.cmd = CMD_UNUSED;
		end
		return r;
	endfunction

	// Present one request after the current burst's pacing and hold it until taken.
	task automatic send_request(input arp_req_t r);
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 9) == 0) ? 80 : $urandom_range(1, 15);
		end
		@(negedge clk);
		in_valid   <= 1'b1;
		command    <= r.cmd;
		hw_type    <= r.hw;
		proto_type <= r.proto;
		arp_opcode <= r.op;
		sender_mac <= r.smac;
		sender_ip  <= r.sip;
		target_ip  <= r.tip;
		query_ip   <= r.qip;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		wait (responses_due == 0);
		repeat (30) @(posedge clk);
	endtask

	task automatic set_local(input logic [IP_W-1:0] ip, input logic [MAC_W-1:0] mac);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= CFG_LOCAL_IP;
		cfg_data  <= {16'($urandom), ip};
		@(negedge clk);
		cfg_index <= CFG_LOCAL_MAC;
		cfg_data  <= mac;
		@(negedge clk);
		cfg_write <= 1'b0;
		local_ip_now = ip;
	endtask

	// Result side: changing stall patterns, plus a long hold-off on request.
	initial begin
		int mode;
		int mode_left;
		int hold_left;
		mode      = 0;
		mode_left = 0;
		hold_left = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_trigger) begin
				hold_trigger = 1'b0;
				hold_left    = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				if (mode_left == 0) begin
					mode      = $urandom_range(0, 3);
					mode_left = $urandom_range(20, 150);
				end
				mode_left--;
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					2: out_stall <= ($urandom_range(0, 3) != 0);
					default: out_stall <= mode_left[0];
				endcase
			end
		end
	end

	// Watchdog: end the run if neither channel moves for too long.
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		logic [IP_W-1:0]  phase_ip  [PHASES];
		logic [MAC_W-1:0] phase_mac [PHASES];
		logic [IP_W-1:0]  home_ip;
		arst_n       = 1'b0;
		cfg_write    = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		in_valid     = 1'b0;
		command      = '0;
		hw_type      = '0;
		proto_type   = '0;
		arp_opcode   = '0;
		sender_mac   = '0;
		sender_ip    = '0;
		target_ip    = '0;
		query_ip     = '0;
		hold_trigger = 1'b0;
		burst_left   = 0;
		local_ip_now = '0;
		for (int i = 0; i < POOL_SIZE; i++)
			ip_pool[i] = $urandom;
		home_ip = $urandom;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		set_local(home_ip, rand48());

		// Directed: empty-cache miss, type checks, each opcode path, lookups, builds, an unused command.
		send_request(mk(CMD_LOOKUP, 0, 0, 0, 0, 0, 0, 0));
		send_request(mk(CMD_RX, 16'h0000, PROTO_IPV4, OP_REQUEST, 0, 0, home_ip, 0));
		send_request(mk(CMD_RX, 16'hffff, PROTO_IPV4, OP_REQUEST, 0, 0, home_ip, 0));
		send_request(mk(CMD_RX, HW_ETHERNET, 16'h0000, OP_REQUEST, 0, 0, home_ip, 0));
		send_request(mk(CMD_RX, HW_ETHERNET, 16'hffff, OP_REQUEST, 0, 0, home_ip, 0));
		send_request(mk(CMD_RX, HW_ETHERNET, PROTO_IPV4, OP_REQUEST, MAC_BCAST,
			ip_pool[0], home_ip, 0));
		send_request(mk(CMD_RX, HW_ETHERNET, PROTO_IPV4, OP_REQUEST, 0,
			ip_pool[1], ~home_ip, 0));
		send_request(mk(CMD_RX, HW_ETHERNET, PROTO_IPV4, OP_REPLY, rand48(),
			ip_pool[0], 0, 0));
		send_request(mk(CMD_RX, HW_ETHERNET, PROTO_IPV4, 16'h0000, 0, 0, 0, 0));
		send_request(mk(CMD_RX, HW_ETHERNET, PROTO_IPV4, 16'hffff, MAC_BCAST,
			'1, '1, '1));
		send_request(mk(CMD_LOOKUP, 0, 0, 0, 0, 0, 0, ip_pool[0]));
		send_request(mk(CMD_LOOKUP, 0, 0, 0, 0, 0, 0, 0));
		send_request(mk(CMD_LOOKUP, 0, 0, 0, 0, 0, 0, '1));
		send_request(mk(CMD_LOOKUP, 0, 0, 0, 0, 0, 0, ip_pool[2]));
		send_request(mk(CMD_BUILD, 0, 0, 0, 0, '1, 0, 0));
		send_request(mk(CMD_BUILD, '1, '1, '1, '1, 0, '1, '1));
		send_request(mk(CMD_UNUSED, '1, '1, '1, '1, '1, '1, '1));
		send_request(mk(CMD_RX, HW_ETHERNET, PROTO_IPV4, OP_REQUEST, rand48(),
			home_ip, home_ip, 0));

		// Fill the cache from the pool until it overflows, then look each one up.
		for (int i = 0; i < POOL_SIZE; i++)
			send_request(mk(CMD_RX, HW_ETHERNET, PROTO_IPV4,
				($urandom_range(0, 1) != 0) ? OP_REQUEST : OP_REPLY, rand48(),
				ip_pool[i], ($urandom_range(0, 1) != 0) ? home_ip : $urandom, $urandom));
		for (int i = 0; i < POOL_SIZE; i++)
			send_request(mk(CMD_LOOKUP, 16'($urandom), 16'($urandom), 16'($urandom),
				rand48(), $urandom, $urandom, ip_pool[i]));

		phase_ip[0]  = '1;          phase_mac[0] = '1;
		phase_ip[1]  = '0;          phase_mac[1] = '0;
		phase_ip[2]  = $urandom;    phase_mac[2] = rand48();
		phase_ip[3]  = ip_pool[2];  phase_mac[3] = rand48();
		phase_ip[4]  = $urandom;    phase_mac[4] = rand48();

		for (int p = 0; p < PHASES; p++) begin
			drain();
			set_local(phase_ip[p], phase_mac[p]);
			// Hold the result side off while requests keep coming.
			if (p == 1)
				hold_trigger = 1'b1;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (p == 3 && n == PHASE_ITEMS / 2) begin
					@(negedge clk);
					in_valid <= 1'b0;
					wait (responses_due == 0);
				end
				send_request(random_request());
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;
		wait (responses_due == 0);
		repeat (40) @(posedge clk);
		if (mismatches == 0 && responses_due == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
`default_nettype wire

### sim.f
rtl/arpc_pkg.sv
rtl/arpc_ram.sv
rtl/arpc_cache.sv
rtl/arp_responder_with_cache.sv
rtl/arpc_chk.sv
bench/arp_checker.sv
bench/tb.sv
